// File: sv/sksi_pkg.sv
// Shared constants and types for the sorted key set block.
// No dependencies; used by sksi_engine and the top level through scoped names.
`timescale 1ns / 1ps

package sksi_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int POS_W       = 7;   // width of position / entries_now fields

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [KEY_WIDTH-1:0] key;
    } req_t;

    typedef struct packed {
        logic             overflow;
        logic [POS_W-1:0] entries_now;
        logic [POS_W-1:0] position;
        logic             found;
    } res_t;

endpackage

// File: sv/sksi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sksi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/sksi_engine.sv
// Search/insert sequencer: binary search with one shared comparator over the
// key RAM, then an entry-by-entry upward shift for inserts. Uses sksi_pkg.
`timescale 1ns / 1ps

module sksi_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            req_valid,
    input  sksi_pkg::req_t                  req,
    output logic                            req_ready,
    output logic                            res_valid,
    output sksi_pkg::res_t                  res,
    input  logic                            res_ready,
    output logic [sksi_pkg::IDX_W-1:0]      rd_addr,
    input  logic [sksi_pkg::KEY_WIDTH-1:0]  rd_data,
    output logic                            wr_en,
    output logic [sksi_pkg::IDX_W-1:0]      wr_addr,
    output logic [sksi_pkg::KEY_WIDTH-1:0]  wr_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_SHRD = 3'd3;
    localparam logic [2:0] ST_SHWR = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [sksi_pkg::CNT_W-1:0] FULL = sksi_pkg::CNT_W'(sksi_pkg::TABLE_DEPTH);
    localparam logic [sksi_pkg::CNT_W-1:0] ONE  = sksi_pkg::CNT_W'(1);

    logic [2:0]                       state_reg, state_next;
    logic [sksi_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [sksi_pkg::CNT_W-1:0]       lo_reg, lo_next;
    logic [sksi_pkg::CNT_W-1:0]       hi_reg, hi_next;
    logic [sksi_pkg::CNT_W-1:0]       mid_reg, mid_next;
    logic [sksi_pkg::CNT_W-1:0]       j_reg, j_next;
    logic                             found_reg, found_next;
    logic                             ovf_reg, ovf_next;
    logic                             op_reg, op_next;
    logic [sksi_pkg::KEY_WIDTH-1:0]   key_reg, key_next;
    logic [sksi_pkg::CNT_W-1:0]       mid;
    logic [sksi_pkg::CNT_W-1:0]       j_dec;
    logic                             key_lt, key_eq;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign j_dec  = j_reg - ONE;
    // the one shared compare unit
    assign key_lt = rd_data < key_reg;
    assign key_eq = rd_data == key_reg;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.found       = found_reg;
    assign res.position    = sksi_pkg::POS_W'(lo_reg);
    assign res.entries_now = sksi_pkg::POS_W'(count_reg);
    assign res.overflow    = ovf_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        j_next     = j_reg;
        found_next = found_reg;
        ovf_next   = ovf_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        rd_addr    = j_dec[sksi_pkg::IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = j_reg[sksi_pkg::IDX_W-1:0];
        wr_data    = rd_data;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    op_next    = req.op;
                    key_next   = req.key;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    found_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                rd_addr = mid[sksi_pkg::IDX_W-1:0];
                if (lo_reg < hi_reg) begin
                    mid_next   = mid;
                    state_next = ST_CMP;
                end else if (op_reg == sksi_pkg::OP_INSERT && !found_reg) begin
                    if (count_reg == FULL) begin
                        ovf_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        j_next     = count_reg;
                        state_next = ST_SHRD;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP: begin
                if (key_lt) begin
                    lo_next = mid_reg + ONE;
                end else begin
                    hi_next = mid_reg;
                end
                // keys are distinct, so a match can only sit at the final position
                if (key_eq) begin
                    found_next = 1'b1;
                end
                state_next = ST_RD;
            end
            ST_SHRD: begin
                if (j_reg > lo_reg) begin
                    state_next = ST_SHWR;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = lo_reg[sksi_pkg::IDX_W-1:0];
                    wr_data    = key_reg;
                    count_next = count_reg + ONE;
                    state_next = ST_DONE;
                end
            end
            ST_SHWR: begin
                wr_en      = 1'b1;
                j_next     = j_dec;
                state_next = ST_SHRD;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        j_reg     <= j_next;
        found_reg <= found_next;
        ovf_reg   <= ovf_next;
        op_reg    <= op_next;
        key_reg   <= key_next;
    end

endmodule

// File: sv/sorted_key_set_insert_lookup.sv
// Top level of the sorted key set: stream ports, output register, key RAM
// and the search/insert engine. Uses sksi_pkg, sksi_ram, sksi_engine.
`timescale 1ns / 1ps

// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+------------------------------------------
// request   | in  | s_tvalid/s_tready  | s_tdata: key[31:0]; s_tuser: op
// result    | out | m_tvalid/m_tready  | m_tdata: found, position, entries_now, ovf
//
// One item at a time: each binary-search step is a RAM read, then a compare;
// an insert then moves each larger entry up with a RAM read and a write, and
// last writes the key; the registered key RAM read sets that pace.
// aresetn (synchronous) empties the table at once; no clearing pass is needed.
// A finished result sits in the output register; the engine holds it until that
// register is free, and s_tready stays low while a request is in progress.

module sorted_key_set_insert_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic        s_tuser,   // [0] op: 0 lookup, 1 insert
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] found, [7:1] position, [14:8] entries_now,
                                   // [15] overflow
);

    sksi_pkg::req_t                 req;
    sksi_pkg::res_t                 res;
    logic                           res_valid, res_ready;
    logic [sksi_pkg::IDX_W-1:0]     rd_addr, wr_addr;
    logic [sksi_pkg::KEY_WIDTH-1:0] rd_data, wr_data;
    logic                           wr_en;
    logic                           m_tvalid_reg, m_tvalid_next;
    sksi_pkg::res_t                 m_res_reg, m_res_next;

    assign req.op  = s_tuser;
    assign req.key = s_tdata[sksi_pkg::KEY_WIDTH-1:0];

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_res_reg;

    sksi_ram #(
        .WIDTH(sksi_pkg::KEY_WIDTH),
        .DEPTH(sksi_pkg::TABLE_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sksi_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (s_tready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

endmodule
